// ----- rtl/core/mkpq_pkg.sv -----
package mkpq_pkg;

    localparam int CAPACITY  = 64;
    localparam int PAYLOAD_W = 32;
    localparam int STAMP_W   = 48;
    localparam int COST_W    = 16;
    localparam int SLOT_W    = 6;
    localparam int OCC_W     = 7;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam logic [1:0] ORD_NEWEST = 2'd0;
    localparam logic [1:0] ORD_COST_A = 2'd1;
    localparam logic [1:0] ORD_COST_B = 2'd2;
    localparam logic [1:0] ORD_COST_C = 2'd3;

    localparam logic CFG_SCHED_LEN   = 1'b0;
    localparam logic CFG_SCHED_ORDER = 1'b1;

    typedef struct packed {
        logic [1:0]                action;
        logic [PAYLOAD_W-1:0]      payload;
        logic [STAMP_W-1:0]        stamp;
        logic signed [COST_W-1:0]  cost_a;
        logic signed [COST_W-1:0]  cost_b;
        logic signed [COST_W-1:0]  cost_c;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic [SLOT_W-1:0]         slot_used;
        logic [PAYLOAD_W-1:0]      out_payload;
        logic [STAMP_W-1:0]        out_stamp;
        logic signed [COST_W-1:0]  out_cost_a;
        logic signed [COST_W-1:0]  out_cost_b;
        logic signed [COST_W-1:0]  out_cost_c;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

endpackage

// ----- rtl/core/multi_key_priority_queue.sv -----
// Push, clear, no-op and a pop on an empty store go through S_FREE_RD,
// S_FREE_WAIT and S_RESULT. A pop on a non-empty store walks every slot through
// the entry memory, one read per cycle, in S_SCAN and S_SCAN_LAST, then S_RESULT.
// One item is in flight at a time; the next beat is taken in the cycle after the
// result is built, even while that result still waits on the output.
// Reset (synchronous, active low) empties the store, rewinds the schedule
// and loads the schedule registers with length 1 and order 0.
module multi_key_priority_queue
    import mkpq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // One memory word holds a whole entry: payload, stamp and three costs.
    typedef struct packed {
        logic [PAYLOAD_W-1:0] payload;
        logic [STAMP_W-1:0]   stamp;
        logic [COST_W-1:0]    cost_a;
        logic [COST_W-1:0]    cost_b;
        logic [COST_W-1:0]    cost_c;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE, S_FREE_RD, S_FREE_WAIT, S_SCAN, S_SCAN_LAST, S_RESULT
    } t_state;

    t_entry           r_mem [CAPACITY];
    logic [IDX_W-1:0] r_stack [CAPACITY];
    t_entry           r_rd_entry;
    logic [IDX_W-1:0] r_stack_rd;
    logic [CAPACITY-1:0] r_valid;

    t_state           r_state;
    t_in_item         r_item;
    logic [CNT_W-1:0] r_top, r_fresh, r_count;
    logic [2:0]       r_sched_idx;
    logic [3:0]       r_sched_len;
    logic [15:0]      r_sched_order;
    logic [1:0]       r_ord;
    logic [IDX_W-1:0] r_addr;   // address being read this cycle
    logic [IDX_W-1:0] r_cand;   // slot whose data arrives this cycle
    logic             r_cand_ok;
    logic             r_found;
    logic [IDX_W-1:0] r_best;
    t_entry           r_best_e;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    t_entry           mem_wd;
    logic             stk_we;
    logic [IDX_W-1:0] stk_wa, stk_wd;

    t_out_item        n_out;
    logic [IDX_W-1:0] push_slot;

    // The result register is free when empty or when its beat leaves this cycle.
    logic             result_go;
    assign result_go = (r_state == S_RESULT) && (!r_out_valid || !i_out_stall);

    // Effective schedule length and selected ordering.
    logic [3:0] len_eff;
    logic [2:0] pos;
    logic [1:0] ord_id;
    always_comb begin
        len_eff = r_sched_len;
        if (len_eff == 4'd0) len_eff = 4'd1;
        if (len_eff > 4'd8) len_eff = 4'd8;
        pos = ({1'b0, r_sched_idx} >= len_eff) ? 3'd0 : r_sched_idx;
        ord_id = r_sched_order[{pos, 1'b0} +: 2];
    end

    // Ranking: does the incoming entry beat the current best?
    logic [COST_W-1:0] key_new, key_best;
    logic              beats;
    always_comb begin
        case (r_ord)
            ORD_COST_A: begin key_new = r_rd_entry.cost_a; key_best = r_best_e.cost_a; end
            ORD_COST_B: begin key_new = r_rd_entry.cost_b; key_best = r_best_e.cost_b; end
            ORD_COST_C: begin key_new = r_rd_entry.cost_c; key_best = r_best_e.cost_c; end
            default:    begin key_new = '0; key_best = '0; end
        endcase
        if (r_ord != ORD_NEWEST && key_new != key_best)
            beats = $signed(key_new) < $signed(key_best);
        else
            beats = r_rd_entry.stamp > r_best_e.stamp;
    end

    // A waiting result does not hold back the input; it holds back only the
    // next item's result.
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Memories: one write port each, registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rd_entry <= r_mem[r_addr];
        if (stk_we) r_stack[stk_wa] <= stk_wd;
        r_stack_rd <= r_stack[r_top[IDX_W-1:0] - IDX_W'(1)];
    end

    // Push writes its entry at the slot taken from the free stack or the
    // fresh counter; pop pushes the freed slot onto the stack.
    always_comb begin
        mem_we = 1'b0;
        mem_wa = push_slot;
        mem_wd = t_entry'({r_item.payload, r_item.stamp,
                           r_item.cost_a, r_item.cost_b, r_item.cost_c});
        stk_we = 1'b0;
        stk_wa = r_top[IDX_W-1:0];
        stk_wd = r_best;
        if (result_go && r_item.action == ACT_PUSH &&
            r_count < CNT_W'(CAPACITY))
            mem_we = 1'b1;
        if (result_go && r_item.action == ACT_POP && r_found &&
            r_top < CNT_W'(CAPACITY))
            stk_we = 1'b1;
    end

    always_comb begin
        push_slot = (r_top != '0) ? r_stack_rd : r_fresh[IDX_W-1:0];
        n_out = '0;
        n_out.occupancy = OCC_W'(r_count);
        case (r_item.action)
            ACT_PUSH: begin
                if (r_count >= CNT_W'(CAPACITY)) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.slot_used = SLOT_W'(push_slot);
                    n_out.occupancy = OCC_W'(r_count + CNT_W'(1));
                end
            end
            ACT_POP: begin
                if (!r_found) begin
                    n_out.status = ST_EMPTY;
                end else begin
                    n_out.slot_used   = SLOT_W'(r_best);
                    n_out.out_payload = r_best_e.payload;
                    n_out.out_stamp   = r_best_e.stamp;
                    n_out.out_cost_a  = r_best_e.cost_a;
                    n_out.out_cost_b  = r_best_e.cost_b;
                    n_out.out_cost_c  = r_best_e.cost_c;
                    n_out.occupancy   = OCC_W'(r_count - CNT_W'(1));
                end
            end
            ACT_CLEAR: n_out.occupancy = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_top         <= '0;
            r_fresh       <= '0;
            r_count       <= '0;
            r_sched_idx   <= '0;
            r_sched_len   <= 4'd1;
            r_sched_order <= '0;
            r_out_valid   <= 1'b0;
            r_addr        <= '0;
            r_found       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == CFG_SCHED_LEN) r_sched_len <= i_cfg_data[3:0];
                else r_sched_order <= i_cfg_data;
            end
            if (result_go) r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && !o_in_stall) begin
                        r_item  <= i_in_data;
                        r_found <= 1'b0;
                        r_addr  <= '0;
                        r_state <= S_FREE_RD;
                        r_ord   <= ord_id;
                    end
                end
                S_FREE_RD: begin
                    // Free-stack read and slot 0 read both land next cycle.
                    r_cand    <= r_addr;
                    r_cand_ok <= r_valid[r_addr];
                    if (r_item.action == ACT_POP && r_count != '0) begin
                        r_state <= (CAPACITY == 1) ? S_SCAN_LAST : S_SCAN;
                        r_addr  <= r_addr + IDX_W'(1);
                    end else begin
                        r_state <= S_FREE_WAIT;
                    end
                end
                S_FREE_WAIT: r_state <= S_RESULT;
                S_SCAN, S_SCAN_LAST: begin
                    if (r_cand_ok && (!r_found || beats)) begin
                        r_found  <= 1'b1;
                        r_best   <= r_cand;
                        r_best_e <= r_rd_entry;
                    end
                    r_cand    <= r_addr;
                    r_cand_ok <= r_valid[r_addr];
                    if (r_state == S_SCAN_LAST) begin
                        r_state <= S_RESULT;
                    end else begin
                        if (r_addr == IDX_W'(CAPACITY - 1)) r_state <= S_SCAN_LAST;
                        else r_addr <= r_addr + IDX_W'(1);
                    end
                end
                S_RESULT: begin
                    if (result_go) begin
                        r_out   <= n_out;
                        r_state <= S_IDLE;
                        case (r_item.action)
                            ACT_PUSH: if (r_count < CNT_W'(CAPACITY)) begin
                                r_valid[push_slot] <= 1'b1;
                                r_count <= r_count + CNT_W'(1);
                                if (r_top != '0) r_top <= r_top - CNT_W'(1);
                                else r_fresh <= r_fresh + CNT_W'(1);
                            end
                            ACT_POP: if (r_found) begin
                                r_valid[r_best] <= 1'b0;
                                r_count <= r_count - CNT_W'(1);
                                if (r_top < CNT_W'(CAPACITY)) r_top <= r_top + CNT_W'(1);
                                r_sched_idx <= ({1'b0, pos} + 4'd1 >= len_eff) ?
                                               3'd0 : pos + 3'd1;
                            end
                            ACT_CLEAR: begin
                                r_valid     <= '0;
                                r_top       <= '0;
                                r_fresh     <= '0;
                                r_count     <= '0;
                                r_sched_idx <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- tb/multi_key_priority_queue_test.sv -----
module multi_key_priority_queue_test;
    import mkpq_pkg::*;

    localparam int SLOTS = 64;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    logic [15:0] i_cfg_data;

    multi_key_priority_queue i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Our own copy of the store: the predictor mirrors every field of every slot.
    logic [PAYLOAD_W-1:0] slot_payload [SLOTS];
    logic [STAMP_W-1:0]   slot_stamp [SLOTS];
    logic [COST_W-1:0]    slot_cost [SLOTS][3];
    bit                   slot_live [SLOTS];
    logic [SLOT_W-1:0]    freed_slots [SLOTS];
    int                   freed_top;
    int                   fresh_slot;
    int                   live_count;
    int                   sched_pos;
    logic [3:0]           sched_len;
    logic [15:0]          sched_order;

    t_out_item pending_results [$];
    bit        failed;

    // Percentages of idle sender cycles and stalled receiver cycles.
    int send_idle_pct;
    int recv_stall_pct;

    // The live pool size is kept track of so that the predictor can tell a full
    // store and an empty store apart.

    // True when slot a ranks strictly ahead of slot b under the given ordering.
    function automatic bit ranks_ahead(int ord, int a, int b);
        logic [COST_W-1:0] ca;
        logic [COST_W-1:0] cb;
        if (ord != ORD_NEWEST) begin
            ca = slot_cost[a][ord-1] ^ COST_W'(1 << (COST_W - 1));
            cb = slot_cost[b][ord-1] ^ COST_W'(1 << (COST_W - 1));
            if (ca != cb) return ca < cb;
        end
        return slot_stamp[a] > slot_stamp[b];
    endfunction

    task automatic predict_queue_step(input t_in_item it);
        t_out_item r;
        int        slot;
        int        len;
        int        pos;
        int        ord;
        int        best;
        r = '0;
        case (t_action'(it.action))
            ACT_PUSH: begin
                if (live_count >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    if (freed_top > 0) begin
                        freed_top--;
                        slot = freed_slots[freed_top];
                    end else begin
                        slot = fresh_slot % SLOTS;
                        fresh_slot++;
                    end
                    slot_payload[slot] = it.payload;
                    slot_stamp[slot]   = it.stamp;
                    slot_cost[slot][0] = it.cost_a;
                    slot_cost[slot][1] = it.cost_b;
                    slot_cost[slot][2] = it.cost_c;
                    slot_live[slot]    = 1'b1;
                    live_count++;
                    r.slot_used = SLOT_W'(slot);
                end
            end
            ACT_POP: begin
                if (live_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // A zero length counts as one, and anything past eight saturates.
                    len = (sched_len == 0) ? 1 : ((sched_len > 8) ? 8 : sched_len);
                    pos = (sched_pos >= len) ? 0 : sched_pos;
                    ord = (sched_order >> (2 * pos)) & 3;
                    sched_pos = (pos + 1 >= len) ? 0 : pos + 1;
                    best = -1;
                    for (int s = 0; s < SLOTS; s++) begin
                        if (slot_live[s] && (best < 0 || ranks_ahead(ord, s, best))) begin
                            best = s;
                        end
                    end
                    slot_live[best] = 1'b0;
                    if (freed_top < SLOTS) begin
                        freed_slots[freed_top] = SLOT_W'(best);
                        freed_top++;
                    end
                    live_count--;
                    r.slot_used   = SLOT_W'(best);
                    r.out_payload = slot_payload[best];
                    r.out_stamp   = slot_stamp[best];
                    r.out_cost_a  = slot_cost[best][0];
                    r.out_cost_b  = slot_cost[best][1];
                    r.out_cost_c  = slot_cost[best][2];
                end
            end
            ACT_CLEAR: begin
                for (int s = 0; s < SLOTS; s++) begin
                    slot_live[s] = 1'b0;
                end
                freed_top  = 0;
                fresh_slot = 0;
                live_count = 0;
                sched_pos  = 0;
            end
            default: begin
            end
        endcase
        r.occupancy = OCC_W'(live_count);
        pending_results.push_back(r);
    endtask

    // Offers one beat, idling beforehand at the current rate, and holds it
    // until the block takes it. The expectation is queued as the beat is taken.
    // Valid stays up afterwards until the next beat or an idle cycle replaces it.
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        predict_queue_step(it);
    endtask

    function automatic t_in_item make_item(input t_action act);
        t_in_item it;
        it.action  = act;
        it.payload = $urandom;
        it.stamp   = STAMP_W'({$urandom, $urandom});
        it.cost_a  = COST_W'($urandom);
        it.cost_b  = COST_W'($urandom);
        it.cost_c  = COST_W'($urandom);
        return it;
    endfunction

    // Costs drawn from a narrow band make ties common, so the stamp and slot
    // tie-breaks are exercised as well as the plain comparisons.
    function automatic t_in_item make_tied_item(input t_action act);
        t_in_item it;
        it = make_item(act);
        it.cost_a = $signed(5'($urandom_range(31))) - 16'sd3;
        it.cost_b = COST_W'($urandom_range(3));
        it.cost_c = -$signed(16'($urandom_range(2)));
        it.stamp  = STAMP_W'($urandom_range(7));
        return it;
    endfunction

    // Drains all outstanding results, then leaves time for any work still
    // in flight (a pop walks the whole store) before anything else happens.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SLOTS + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        if (idx == CFG_SCHED_LEN) begin
            sched_len = val[3:0];
        end else begin
            sched_order = val;
        end
    endtask

    task automatic set_schedule(input logic [3:0] len, input logic [15:0] order);
        wait_idle();
        write_reg(CFG_SCHED_LEN, {12'd0, len});
        write_reg(CFG_SCHED_ORDER, order);
        i_cfg_valid <= 1'b0;
    endtask

    // Result checker: every beat the block hands over is held against the oldest
    // expectation. The receiver stalls at random at the current rate.
    always @(posedge i_clk) begin
        t_out_item exp_item;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result beat %h", $time, o_out_data);
                    failed = 1'b1;
                end else begin
                    exp_item = pending_results.pop_front();
                    if (o_out_data !== exp_item) begin
                        $display("%0t: result mismatch expected %h actual %h",
                                 $time, exp_item, o_out_data);
                        $display("  status %0d/%0d slot %0d/%0d occupancy %0d/%0d",
                                 exp_item.status, o_out_data.status,
                                 exp_item.slot_used, o_out_data.slot_used,
                                 exp_item.occupancy, o_out_data.occupancy);
                        failed = 1'b1;
                    end
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Extremes of every field, every action, empty and full stores.
    task automatic test_directed();
        t_in_item it;
        send_item(make_item(ACT_POP));
        it = '0;
        it.action = ACT_PUSH;
        it.payload = '1;
        it.stamp = '1;
        it.cost_a = 16'sh8000;
        it.cost_b = 16'sh7fff;
        it.cost_c = 16'sh8000;
        send_item(it);
        it.payload = '0;
        it.stamp = '0;
        it.cost_a = 16'sh7fff;
        it.cost_b = 16'sh8000;
        it.cost_c = 16'sh7fff;
        send_item(it);
        send_item(make_item(ACT_NOP));
        send_item(make_item(ACT_POP));
        send_item(make_item(ACT_POP));
        send_item(make_item(ACT_POP));
        send_item(make_item(ACT_PUSH));
        send_item(make_item(ACT_CLEAR));
        send_item(make_item(ACT_NOP));
        // Fill to the brim and one more, then pop from a full store.
        for (int k = 0; k < SLOTS + 1; k++) begin
            send_item(make_tied_item(ACT_PUSH));
        end
        send_item(make_item(ACT_POP));
        send_item(make_item(ACT_PUSH));
        send_item(make_item(ACT_CLEAR));
    endtask

    // Random traffic: runs of pushes and pops with the push share drifting so
    // that the store passes through both empty and full.
    task automatic test_random(input int count);
        int push_pct;
        int roll;
        push_pct = 60;
        for (int k = 0; k < count; k++) begin
            if (k % 100 == 0) push_pct = $urandom_range(25, 85);
            roll = $urandom_range(999);
            if (roll < 6) begin
                send_item(make_item(ACT_CLEAR));
            end else if (roll < 12) begin
                send_item(make_item(ACT_NOP));
            end else if (roll % 100 < push_pct) begin
                send_item((roll & 1) ? make_tied_item(ACT_PUSH) : make_item(ACT_PUSH));
            end else begin
                send_item(make_item(ACT_POP));
            end
        end
    endtask

    task automatic test_schedules();
        // Each phase picks a schedule, including the out-of-range lengths.
        set_schedule(4'd8, 16'b11_10_01_00_11_10_01_00);
        test_random(150);
        set_schedule(4'd15, 16'($urandom));
        test_random(100);
        set_schedule(4'd0, 16'hffff);
        test_random(100);
        set_schedule(4'd3, 16'b00_00_00_00_00_11_10_01);
        test_random(100);
        // Shrinking the length mid-schedule makes the position wrap.
        set_schedule(4'd1, 16'h0002);
        test_random(100);
    endtask

    task automatic test_idle_phases();
        send_idle_pct = 61;
        recv_stall_pct = 0;
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 61;
        test_random(200);
        send_idle_pct = 33;
        recv_stall_pct = 33;
        set_schedule(4'($urandom_range(1, 8)), 16'($urandom));
        test_random(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        set_schedule(4'($urandom_range(1, 8)), 16'($urandom));
        test_random(150);
    endtask

    initial begin
        failed = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        freed_top = 0;
        fresh_slot = 0;
        live_count = 0;
        sched_pos = 0;
        sched_len = 4'd1;
        sched_order = 16'd0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_live[s] = 1'b0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SCHED_LEN;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_schedules();
        test_idle_phases();

        wait_idle();
        if (!failed) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("simulation failed");
        $finish;
    end

endmodule
